// ----- hw/rtl/pressure_temperature_compensation_top_defines.svh -----
// assertion macros for the compensation block checker
`ifndef PRESSURE_TEMPERATURE_COMPENSATION_TOP_DEFINES_SVH
`define PRESSURE_TEMPERATURE_COMPENSATION_TOP_DEFINES_SVH

// clocked assertion with explicit clock and reset
`define PTC_ASSERT_CLK(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("ptc assertion failed");

// clocked assertion on the block clock and reset
`define PTC_ASSERT(lbl, prop) `PTC_ASSERT_CLK(lbl, clock, reset, prop)

`endif

// ----- hw/rtl/ptc_pkg.sv -----
// shared types and constants for the pressure and temperature compensation block
package ptc_pkg;

   localparam int RAW_W     = 24;
   localparam int CAL_W     = 16;
   localparam int TEMP_W    = 19;
   localparam int PRES_W    = 32;
   localparam int CSR_IDX_W = 3;

   localparam int NUM_STAGES = 9;

   localparam int SH_REF       = 8;
   localparam int SH_TEMP      = 23;
   localparam int SH_T2        = 33;
   localparam int SH_OFF_BASE  = 18;
   localparam int SH_SENS_BASE = 17;
   localparam int SH_OFF_TC    = 5;
   localparam int SH_SENS_TC   = 7;
   localparam int SH_PMUL      = 21;
   localparam int SH_POUT      = 15;

   localparam int T_KNEE     = 2000;
   localparam int T_COLD_MAG = 1500;

   localparam int DT_W     = RAW_W + 2;
   localparam int MUL_W    = DT_W + CAL_W + 1;
   localparam int SQ_DT_W  = 2 * DT_W;
   localparam int T2Q_W    = SQ_DT_W - SH_T2;
   localparam int TQ_W     = MUL_W - SH_TEMP;
   localparam int DK_W     = TEMP_W + 1;
   localparam int SQ_W     = 2 * DK_W;
   localparam int ACC_W    = 40;
   localparam int SENS2_W  = SQ_W + 2;
   localparam int SPLIT_W  = 20;
   localparam int PP_LO_W  = SPLIT_W + RAW_W;
   localparam int PP_HI_W  = (ACC_W - SPLIT_W) + RAW_W + 1;
   localparam int PROD_W   = PP_HI_W + SPLIT_W + 1;
   localparam int PSH_W    = PROD_W - SH_PMUL;
   localparam int DIFF_W   = PSH_W + 1;

   localparam logic [CSR_IDX_W-1:0] CSR_C1 = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_C2 = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_C3 = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_C4 = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_C5 = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_C6 = 3'd5;

   typedef struct packed {
      logic [CAL_W-1:0] c1;
      logic [CAL_W-1:0] c2;
      logic [CAL_W-1:0] c3;
      logic [CAL_W-1:0] c4;
      logic [CAL_W-1:0] c5;
      logic [CAL_W-1:0] c6;
   } cal_type;

   typedef struct packed {
      logic signed [TEMP_W-1:0] temp;
      logic signed [ACC_W-1:0]  off;
      logic signed [ACC_W-1:0]  sens;
      logic [T2Q_W-1:0]         t2q;
      logic [RAW_W-1:0]         d1;
   } first_type;

   typedef struct packed {
      logic signed [TEMP_W-1:0] temp;
      logic signed [ACC_W-1:0]  off_net;
      logic signed [ACC_W-1:0]  sens_net;
      logic [RAW_W-1:0]         d1;
   } second_type;

endpackage

// ----- hw/rtl/ptc_first_order.sv -----
// first-order stages: temperature difference, products, temp, offset and sensitivity
module ptc_first_order (
   input  logic                             clock,
   input  logic [2:0]                       stage_en,
   input  ptc_pkg::cal_type                 cal,
   input  logic [ptc_pkg::RAW_W-1:0]        raw_temperature,
   input  logic [ptc_pkg::RAW_W-1:0]        raw_pressure,
   output ptc_pkg::first_type               first_out
);
   import ptc_pkg::*;

   logic signed [DT_W-1:0]    dt_in, dt_ff;
   logic [RAW_W-1:0]          d1_s1_ff, d1_s2_ff;
   logic signed [MUL_W-1:0]   mul_temp_in, mul_temp_ff;
   logic signed [MUL_W-1:0]   mul_off_in, mul_off_ff;
   logic signed [MUL_W-1:0]   mul_sens_in, mul_sens_ff;
   logic signed [SQ_DT_W-1:0] sq_dt_in, sq_dt_ff;
   logic signed [TQ_W-1:0]    tq;
   logic signed [TQ_W-1:0]    temp_wide;
   logic signed [MUL_W-SH_OFF_TC-1:0]  off_tc;
   logic signed [MUL_W-SH_SENS_TC-1:0] sens_tc;
   first_type                 first_in, first_ff;

   // stage 1: dt = d2 - c5 * 256
   assign dt_in = $signed({2'b00, raw_temperature})
                - $signed({2'b00, cal.c5, {SH_REF{1'b0}}});

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         dt_ff    <= dt_in;
         d1_s1_ff <= raw_pressure;
      end
   end

   // stage 2: products of dt
   assign mul_temp_in = dt_ff * $signed({1'b0, cal.c6});
   assign mul_off_in  = dt_ff * $signed({1'b0, cal.c4});
   assign mul_sens_in = dt_ff * $signed({1'b0, cal.c3});
   assign sq_dt_in    = dt_ff * dt_ff;

   always_ff @(posedge clock) begin
      if (stage_en[1]) begin
         mul_temp_ff <= mul_temp_in;
         mul_off_ff  <= mul_off_in;
         mul_sens_ff <= mul_sens_in;
         sq_dt_ff    <= sq_dt_in;
         d1_s2_ff    <= d1_s1_ff;
      end
   end

   // stage 3: floor shifts and bases
   assign tq        = mul_temp_ff[MUL_W-1:SH_TEMP];
   assign temp_wide = tq + TQ_W'(T_KNEE);
   assign off_tc    = mul_off_ff[MUL_W-1:SH_OFF_TC];
   assign sens_tc   = mul_sens_ff[MUL_W-1:SH_SENS_TC];

   always_comb begin
      first_in.temp = temp_wide[TEMP_W-1:0];
      first_in.off  = $signed({{(ACC_W-CAL_W-SH_OFF_BASE){1'b0}}, cal.c2,
                               {SH_OFF_BASE{1'b0}}}) + ACC_W'(off_tc);
      first_in.sens = $signed({{(ACC_W-CAL_W-SH_SENS_BASE){1'b0}}, cal.c1,
                               {SH_SENS_BASE{1'b0}}}) + ACC_W'(sens_tc);
      first_in.t2q  = sq_dt_ff[SQ_DT_W-1:SH_T2];
      first_in.d1   = d1_s2_ff;
   end

   always_ff @(posedge clock) begin
      if (stage_en[2]) begin
         first_ff <= first_in;
      end
   end

   assign first_out = first_ff;

endmodule

// ----- hw/rtl/ptc_second_order.sv -----
// second-order stages: low and very low temperature corrections
module ptc_second_order (
   input  logic                 clock,
   input  logic [2:0]           stage_en,
   input  ptc_pkg::first_type   first_in,
   output ptc_pkg::second_type  second_out
);
   import ptc_pkg::*;

   logic signed [DK_W-1:0]   temp_ext;
   logic signed [DK_W-1:0]   dk, dc;
   logic [T2Q_W+1:0]         t2;
   logic signed [T2Q_W+2:0]  temp_t2;
   logic                     knee_in, cold_in;
   logic                     knee_ff, cold_ff;
   logic signed [SQ_W-1:0]   sq_k_in, sq_c_in;
   logic [SQ_W-1:0]          sq_k_ff, sq_c_ff;
   logic signed [TEMP_W-1:0] temp_s4_ff, temp_s5_ff;
   logic signed [ACC_W-1:0]  off_s4_ff, sens_s4_ff, sens_s5_ff;
   logic [RAW_W-1:0]         d1_s4_ff, d1_s5_ff;
   logic [SQ_W+1:0]          sq3_k, sq3_c;
   logic [SQ_W+2:0]          sq7_k;
   logic [SENS2_W-1:0]       sens2_in, sens2_ff;
   logic signed [ACC_W-1:0]  off_net_in, off_net_ff;
   logic signed [SENS2_W-1:0] sens_diff;
   second_type               second_in, second_ff;

   // stage 4: squares of distance to the knees, temperature less t2
   assign temp_ext = DK_W'(first_in.temp);
   assign dk       = temp_ext - DK_W'(T_KNEE);
   assign dc       = temp_ext + DK_W'(T_COLD_MAG);
   assign sq_k_in  = dk * dk;
   assign sq_c_in  = dc * dc;
   assign knee_in  = first_in.temp < TEMP_W'(T_KNEE);
   assign cold_in  = first_in.temp < -TEMP_W'(T_COLD_MAG);
   assign t2       = {2'b00, first_in.t2q} + {1'b0, first_in.t2q, 1'b0};
   assign temp_t2  = (T2Q_W+3)'(first_in.temp)
                   - (knee_in ? $signed({1'b0, t2}) : '0);

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         sq_k_ff    <= sq_k_in;
         sq_c_ff    <= sq_c_in;
         knee_ff    <= knee_in;
         cold_ff    <= cold_in;
         temp_s4_ff <= temp_t2[TEMP_W-1:0];
         off_s4_ff  <= first_in.off;
         sens_s4_ff <= first_in.sens;
         d1_s4_ff   <= first_in.d1;
      end
   end

   // stage 5: off2 applied, sens2 formed
   assign sq3_k = {2'b00, sq_k_ff} + {1'b0, sq_k_ff, 1'b0};
   assign sq7_k = {sq_k_ff, 3'b000} - {3'b000, sq_k_ff};
   assign sq3_c = {2'b00, sq_c_ff} + {1'b0, sq_c_ff, 1'b0};

   always_comb begin
      off_net_in = off_s4_ff;
      sens2_in   = '0;
      if (knee_ff) begin
         off_net_in = off_s4_ff - $signed({1'b0, sq3_k[SQ_W+1:3]});
         sens2_in   = SENS2_W'(sq7_k[SQ_W+2:3]) + (cold_ff ? sq3_c : '0);
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[1]) begin
         off_net_ff <= off_net_in;
         sens2_ff   <= sens2_in;
         sens_s5_ff <= sens_s4_ff;
         temp_s5_ff <= temp_s4_ff;
         d1_s5_ff   <= d1_s4_ff;
      end
   end

   // stage 6: net sensitivity
   assign sens_diff = SENS2_W'(sens_s5_ff) - $signed(sens2_ff);

   always_comb begin
      second_in.temp     = temp_s5_ff;
      second_in.off_net  = off_net_ff;
      second_in.sens_net = sens_diff[ACC_W-1:0];
      second_in.d1       = d1_s5_ff;
   end

   always_ff @(posedge clock) begin
      if (stage_en[2]) begin
         second_ff <= second_in;
      end
   end

   assign second_out = second_ff;

endmodule

// ----- hw/rtl/ptc_pressure.sv -----
// pressure stages: split sensitivity product, offset removal, output register
module ptc_pressure (
   input  logic                                clock,
   input  logic [2:0]                          stage_en,
   input  ptc_pkg::second_type                 second_in,
   output logic signed [ptc_pkg::TEMP_W-1:0]   temperature_centi,
   output logic signed [ptc_pkg::PRES_W-1:0]   pressure_deci_mbar
);
   import ptc_pkg::*;

   logic [PP_LO_W-1:0]        pp_lo_in, pp_lo_ff;
   logic signed [PP_HI_W-1:0] pp_hi_in, pp_hi_ff;
   logic signed [ACC_W-1:0]   off_s7_ff, off_s8_ff;
   logic signed [TEMP_W-1:0]  temp_s7_ff, temp_s8_ff, temp_ff;
   logic signed [PROD_W-1:0]  prod;
   logic signed [PSH_W-1:0]   prod_sh_ff;
   logic signed [DIFF_W-1:0]  diff;
   logic signed [PRES_W-1:0]  pres_ff;

   // stage 7: partial products of sens_net and d1
   assign pp_lo_in = second_in.sens_net[SPLIT_W-1:0] * second_in.d1;
   assign pp_hi_in = $signed(second_in.sens_net[ACC_W-1:SPLIT_W])
                   * $signed({1'b0, second_in.d1});

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         pp_lo_ff   <= pp_lo_in;
         pp_hi_ff   <= pp_hi_in;
         off_s7_ff  <= second_in.off_net;
         temp_s7_ff <= second_in.temp;
      end
   end

   // stage 8: combine partial products, floor shift
   assign prod = $signed({pp_hi_ff[PP_HI_W-1], pp_hi_ff, {SPLIT_W{1'b0}}})
               + $signed({{(PROD_W-PP_LO_W){1'b0}}, pp_lo_ff});

   always_ff @(posedge clock) begin
      if (stage_en[1]) begin
         prod_sh_ff <= prod[PROD_W-1:SH_PMUL];
         off_s8_ff  <= off_s7_ff;
         temp_s8_ff <= temp_s7_ff;
      end
   end

   // stage 9: remove offset, floor shift; the result always fits 32 signed bits
   assign diff = DIFF_W'(prod_sh_ff) - DIFF_W'(off_s8_ff);

   always_ff @(posedge clock) begin
      if (stage_en[2]) begin
         pres_ff <= PRES_W'($signed(diff[DIFF_W-1:SH_POUT]));
         temp_ff <= temp_s8_ff;
      end
   end

   assign temperature_centi  = temp_ff;
   assign pressure_deci_mbar = pres_ff;

endmodule

// ----- hw/rtl/pressure_temperature_compensation_top.sv -----
// Compensates one raw temperature and pressure reading pair per transfer with six
// calibration words and returns temperature in 0.01 C and pressure in 0.1 mbar.
// The datapath is a nine-stage pipeline: a reading pair can be taken every cycle while the
// result side is not stalled, and its result is offered from the stage 9 output register.
// Each stage holds its item until the next stage frees, so a stall on the
// result side fills the empty stages before input is held off. The 64-bit sensitivity
// product is split into two partial products over two stages. The user must write
// calibration words through the csr port while no item is in flight; the block does not enforce it.
module pressure_temperature_compensation_top (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [ptc_pkg::RAW_W-1:0]          req_raw_temperature,
   input  logic [ptc_pkg::RAW_W-1:0]          req_raw_pressure,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic signed [ptc_pkg::TEMP_W-1:0]  rsp_temperature_centi,
   output logic signed [ptc_pkg::PRES_W-1:0]  rsp_pressure_deci_mbar,
   input  logic                               csr_write_enable,
   input  logic [ptc_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [ptc_pkg::CAL_W-1:0]          csr_write_data
);
   import ptc_pkg::*;

   cal_type                 cal_in, cal_ff;
   logic [NUM_STAGES-1:0]   valid_in, valid_ff;
   logic [NUM_STAGES-1:0]   stage_en;
   first_type               first_bus;
   second_type              second_bus;

   always_comb begin
      cal_in = cal_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_C1:  cal_in.c1 = csr_write_data;
            CSR_C2:  cal_in.c2 = csr_write_data;
            CSR_C3:  cal_in.c3 = csr_write_data;
            CSR_C4:  cal_in.c4 = csr_write_data;
            CSR_C5:  cal_in.c5 = csr_write_data;
            CSR_C6:  cal_in.c6 = csr_write_data;
            default: cal_in = cal_ff;
         endcase
      end
   end

   // a stage loads when it is empty or its successor loads
   always_comb begin
      stage_en[NUM_STAGES-1] = !valid_ff[NUM_STAGES-1] || rsp_ready;
      for (int i = NUM_STAGES - 2; i >= 0; i--) begin
         stage_en[i] = !valid_ff[i] || stage_en[i+1];
      end
   end

   always_comb begin
      valid_in[0] = stage_en[0] ? req_valid : valid_ff[0];
      for (int i = 1; i < NUM_STAGES; i++) begin
         valid_in[i] = stage_en[i] ? valid_ff[i-1] : valid_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cal_ff   <= '0;
         valid_ff <= '0;
      end else begin
         cal_ff   <= cal_in;
         valid_ff <= valid_in;
      end
   end

   assign req_ready = stage_en[0];
   assign rsp_valid = valid_ff[NUM_STAGES-1];

   ptc_first_order u_first_order (
      .clock           (clock),
      .stage_en        (stage_en[2:0]),
      .cal             (cal_ff),
      .raw_temperature (req_raw_temperature),
      .raw_pressure    (req_raw_pressure),
      .first_out       (first_bus)
   );

   ptc_second_order u_second_order (
      .clock      (clock),
      .stage_en   (stage_en[5:3]),
      .first_in   (first_bus),
      .second_out (second_bus)
   );

   ptc_pressure u_pressure (
      .clock              (clock),
      .stage_en           (stage_en[8:6]),
      .second_in          (second_bus),
      .temperature_centi  (rsp_temperature_centi),
      .pressure_deci_mbar (rsp_pressure_deci_mbar)
   );

endmodule

// ----- hw/rtl/ptc_checker.sv -----
// port-level checker for the compensation block, bound to the top level
`include "pressure_temperature_compensation_top_defines.svh"

module ptc_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_ready,
   input logic                               rsp_valid,
   input logic                               rsp_ready,
   input logic signed [ptc_pkg::TEMP_W-1:0]  rsp_temperature_centi,
   input logic signed [ptc_pkg::PRES_W-1:0]  rsp_pressure_deci_mbar
);

   // a stalled result stays offered
   `PTC_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid)

   // a stalled result keeps its payload
   `PTC_ASSERT(a_rsp_stable, rsp_valid && !rsp_ready |=> $stable(rsp_pressure_deci_mbar) && $stable(rsp_temperature_centi))

   // an empty output stage never holds off input
   `PTC_ASSERT(a_empty_out_ready, !rsp_valid |-> req_ready)

   // a taken result frees the whole pipeline for input
   `PTC_ASSERT(a_drain_ready, rsp_ready |-> req_ready)

   // no result is offered in the cycle in which reset falls
   `PTC_ASSERT(a_no_early_rsp, $fell(reset) |-> !rsp_valid)

endmodule

bind pressure_temperature_compensation_top ptc_checker u_ptc_checker (.*);
